// ===== rtl/vp8lf_pkg.sv =====
package vp8lf_pkg;

	// one edge segment: flags and the eight pixels p3..q3
	typedef struct packed {
		logic       is_special_mode;
		logic       is_subblock;
		logic [7:0] pix_p3;
		logic [7:0] pix_p2;
		logic [7:0] pix_p1;
		logic [7:0] pix_p0;
		logic [7:0] pix_q0;
		logic [7:0] pix_q1;
		logic [7:0] pix_q2;
		logic [7:0] pix_q3;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_p2;
		logic [7:0] out_p1;
		logic [7:0] out_p0;
		logic [7:0] out_q0;
		logic [7:0] out_q1;
		logic [7:0] out_q2;
		logic       applied;
	} out_word_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_FILTER_TYPE   = 3'd0,
		CFG_BASE_LEVEL    = 3'd1,
		CFG_SHARPNESS     = 3'd2,
		CFG_DELTA_ENABLED = 3'd3,
		CFG_REF_DELTA     = 3'd4,
		CFG_MODE_DELTA    = 3'd5
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// filter operation chosen by the front end
	typedef enum logic [1:0] {
		OP_PASS   = 2'd0,  // pixels unchanged
		OP_COMMON = 2'd1,  // p0/q0 adjust with outer taps
		OP_INNER  = 2'd2,  // subblock filter, low variance: p1..q1
		OP_WIDE   = 2'd3   // macroblock 27/18/9 filter
	} op_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] pix_p2;
		logic [7:0] pix_p1;
		logic [7:0] pix_p0;
		logic [7:0] pix_q0;
		logic [7:0] pix_q1;
		logic [7:0] pix_q2;
	} cls_word_t;

	localparam logic [5:0] LVL_MAX  = 6'd63;
	localparam logic [5:0] LVL_HEV2 = 6'd40;
	localparam logic [5:0] LVL_HEV1 = 6'd15;
	localparam logic [3:0] NB_BASE  = 4'd9;
	localparam logic [7:0] MB_EDGE_EXTRA = 8'd4;
	localparam logic [7:0] PIX_BIAS = 8'h80;

	localparam logic signed [15:0] TAP_WIDE  = 16'sd27;
	localparam logic signed [15:0] TAP_MID   = 16'sd18;
	localparam logic signed [15:0] TAP_NEAR  = 16'sd9;
	localparam logic signed [15:0] TAP_ROUND = 16'sd63;

	function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// sign extend an 8 bit two's complement value
	function automatic logic signed [15:0] sx8(input logic [7:0] v);
		return $signed({{8{v[7]}}, v});
	endfunction

	// saturate to signed 8 bits
	function automatic logic [7:0] sat8(input logic signed [15:0] v);
		logic [7:0] r;
		if (v < -16'sd128) begin
			r = 8'h80;
		end else if (v > 16'sd127) begin
			r = 8'h7f;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/vp8lf_front.sv =====
module vp8lf_front
	import vp8lf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	input  in_word_t              item,
	input  logic                  q_full,
	output logic                  q_push,
	output cls_word_t             q_data
);

	logic       filter_type_q;
	logic [5:0] base_level_q;
	logic [2:0] sharpness_q;
	logic       delta_enabled_q;
	logic [6:0] ref_delta_q;
	logic [6:0] mode_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_type_q   <= 1'b0;
			base_level_q    <= '0;
			sharpness_q     <= '0;
			delta_enabled_q <= 1'b0;
			ref_delta_q     <= '0;
			mode_delta_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_FILTER_TYPE:   filter_type_q   <= cfg_wdata[0];
				CFG_BASE_LEVEL:    base_level_q    <= cfg_wdata[5:0];
				CFG_SHARPNESS:     sharpness_q     <= cfg_wdata[2:0];
				CFG_DELTA_ENABLED: delta_enabled_q <= cfg_wdata[0];
				CFG_REF_DELTA:     ref_delta_q     <= cfg_wdata;
				CFG_MODE_DELTA:    mode_delta_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [9:0] lvl_sum;
	logic [5:0] lvl;
	logic [5:0] nb_shift;
	logic [3:0] nb_lim;
	logic [5:0] nb;
	logic [7:0] edge_lim;
	logic [1:0] thr;
	logic [9:0] edge_act;
	logic       edge_ok;
	logic       interior_ok;
	logic       hev;
	logic [7:0] d_p3p2, d_p2p1, d_p1p0, d_q3q2, d_q2q1, d_q1q0, d_p0q0, d_p1q1;
	op_t        op;

	always_comb begin
		// level with deltas, clamped only when deltas apply
		lvl_sum = $signed({4'b0, base_level_q}) + $signed({{3{ref_delta_q[6]}}, ref_delta_q})
			+ (item.is_special_mode ? $signed({{3{mode_delta_q[6]}}, mode_delta_q}) : 10'sd0);
		if (!delta_enabled_q) begin
			lvl = base_level_q;
		end else if (lvl_sum < 10'sd0) begin
			lvl = '0;
		end else if (lvl_sum > $signed({4'b0, LVL_MAX})) begin
			lvl = LVL_MAX;
		end else begin
			lvl = lvl_sum[5:0];
		end

		// neighbor limit from sharpness
		nb_lim = NB_BASE - {1'b0, sharpness_q};
		if (sharpness_q == 3'd0) begin
			nb_shift = lvl;
		end else if (sharpness_q > 3'd4) begin
			nb_shift = lvl >> 2;
		end else begin
			nb_shift = lvl >> 1;
		end
		nb = nb_shift;
		if (sharpness_q != 3'd0 && nb_shift > {2'b0, nb_lim}) begin
			nb = {2'b0, nb_lim};
		end
		if (nb == 6'd0) begin
			nb = 6'd1;
		end

		edge_lim = {1'b0, lvl, 1'b0} + {2'b0, nb} + (item.is_subblock ? 8'd0 : MB_EDGE_EXTRA);

		if (lvl >= LVL_HEV2) begin
			thr = 2'd2;
		end else if (lvl >= LVL_HEV1) begin
			thr = 2'd1;
		end else begin
			thr = 2'd0;
		end

		d_p3p2 = absd(item.pix_p3, item.pix_p2);
		d_p2p1 = absd(item.pix_p2, item.pix_p1);
		d_p1p0 = absd(item.pix_p1, item.pix_p0);
		d_q3q2 = absd(item.pix_q3, item.pix_q2);
		d_q2q1 = absd(item.pix_q2, item.pix_q1);
		d_q1q0 = absd(item.pix_q1, item.pix_q0);
		d_p0q0 = absd(item.pix_p0, item.pix_q0);
		d_p1q1 = absd(item.pix_p1, item.pix_q1);

		edge_act = {1'b0, d_p0q0, 1'b0} + {3'b0, d_p1q1[7:1]};
		edge_ok  = edge_act <= {2'b0, edge_lim};
		interior_ok = (d_p3p2 <= {2'b0, nb}) && (d_p2p1 <= {2'b0, nb})
			&& (d_p1p0 <= {2'b0, nb}) && (d_q3q2 <= {2'b0, nb})
			&& (d_q2q1 <= {2'b0, nb}) && (d_q1q0 <= {2'b0, nb});
		hev = (d_p1p0 > {6'b0, thr}) || (d_q1q0 > {6'b0, thr});

		priority if (lvl == 6'd0 || !edge_ok) begin
			op = OP_PASS;
		end else if (filter_type_q) begin
			op = OP_COMMON;
		end else if (!interior_ok) begin
			op = OP_PASS;
		end else if (hev) begin
			op = OP_COMMON;
		end else if (item.is_subblock) begin
			op = OP_INNER;
		end else begin
			op = OP_WIDE;
		end
	end

	assign q_push = push && !q_full;

	always_comb begin
		q_data.op     = op;
		q_data.pix_p2 = item.pix_p2;
		q_data.pix_p1 = item.pix_p1;
		q_data.pix_p0 = item.pix_p0;
		q_data.pix_q0 = item.pix_q0;
		q_data.pix_q1 = item.pix_q1;
		q_data.pix_q2 = item.pix_q2;
	end

endmodule

// ===== rtl/vp8lf_queue.sv =====
module vp8lf_queue
	import vp8lf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_word_t wdata,
	output logic      full,
	input  logic      pop,
	output cls_word_t rdata,
	output logic      empty
);

	cls_word_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/vp8lf_back.sv =====
module vp8lf_back
	import vp8lf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cls_word_t q_data,
	input  logic      q_empty,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	// stage 1: filter value w, then taps and write back into a two word output queue
	logic       valid_s1;
	cls_word_t  cls_s1;
	logic [7:0] w_s1;

	out_word_t  omem_q [2];
	logic       owr_ptr_q;
	logic       ord_ptr_q;
	logic [1:0] ocnt_q;
	logic       o_push;
	logic       o_pop;
	logic       o_blocked;
	logic       s1_ready;

	logic               outer;
	logic [7:0]         hp1, hp0, hq0, hq1;
	logic [7:0]         pq;
	logic signed [15:0] d3;
	logic [7:0]         w_in;

	always_comb begin
		hp1 = q_data.pix_p1 ^ PIX_BIAS;
		hp0 = q_data.pix_p0 ^ PIX_BIAS;
		hq0 = q_data.pix_q0 ^ PIX_BIAS;
		hq1 = q_data.pix_q1 ^ PIX_BIAS;
		outer = q_data.op != OP_INNER;
		pq = sat8(sx8(hp1) - sx8(hq1));
		d3 = 16'sd3 * (sx8(hq0) - sx8(hp0));
		w_in = sat8((outer ? sx8(pq) : 16'sd0) + d3);
	end

	assign o_pop     = pop && !empty;
	assign o_blocked = (ocnt_q == 2'd2) && !o_pop;
	assign s1_ready  = !valid_s1 || !o_blocked;
	assign q_pop     = !q_empty && s1_ready;
	assign o_push    = valid_s1 && !o_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_s1 <= q_data;
			w_s1   <= w_in;
		end
	end

	logic [7:0]         sp2, sp1, sp0, sq0, sq1, sq2;
	logic signed [15:0] b_t, a2_t, a3_t;
	logic [7:0]         b, a2, a3;
	logic signed [15:0] m27, m18, m9;
	logic [7:0]         t27, t18, t9;
	logic [7:0]         np2, np1, np0, nq0, nq1, nq2;
	out_word_t          o_word;

	always_comb begin
		sp2 = cls_s1.pix_p2 ^ PIX_BIAS;
		sp1 = cls_s1.pix_p1 ^ PIX_BIAS;
		sp0 = cls_s1.pix_p0 ^ PIX_BIAS;
		sq0 = cls_s1.pix_q0 ^ PIX_BIAS;
		sq1 = cls_s1.pix_q1 ^ PIX_BIAS;
		sq2 = cls_s1.pix_q2 ^ PIX_BIAS;

		// common adjustment
		b_t  = sx8(sat8(sx8(w_s1) + 16'sd3)) >>> 3;
		a2_t = sx8(sat8(sx8(w_s1) + 16'sd4)) >>> 3;
		b    = b_t[7:0];
		a2   = a2_t[7:0];
		a3_t = (sx8(a2) + 16'sd1) >>> 1;
		a3   = a3_t[7:0];

		// macroblock taps
		m27 = (TAP_WIDE * sx8(w_s1) + TAP_ROUND) >>> 7;
		m18 = (TAP_MID * sx8(w_s1) + TAP_ROUND) >>> 7;
		m9  = (TAP_NEAR * sx8(w_s1) + TAP_ROUND) >>> 7;
		t27 = sat8(m27);
		t18 = sat8(m18);
		t9  = sat8(m9);

		np2 = sp2;
		np1 = sp1;
		np0 = sp0;
		nq0 = sq0;
		nq1 = sq1;
		nq2 = sq2;
		unique case (cls_s1.op)
			OP_PASS: ;
			OP_COMMON: begin
				np0 = sat8(sx8(sp0) + sx8(b));
				nq0 = sat8(sx8(sq0) - sx8(a2));
			end
			OP_INNER: begin
				np0 = sat8(sx8(sp0) + sx8(b));
				nq0 = sat8(sx8(sq0) - sx8(a2));
				np1 = sat8(sx8(sp1) + sx8(a3));
				nq1 = sat8(sx8(sq1) - sx8(a3));
			end
			OP_WIDE: begin
				np0 = sat8(sx8(sp0) + sx8(t27));
				nq0 = sat8(sx8(sq0) - sx8(t27));
				np1 = sat8(sx8(sp1) + sx8(t18));
				nq1 = sat8(sx8(sq1) - sx8(t18));
				np2 = sat8(sx8(sp2) + sx8(t9));
				nq2 = sat8(sx8(sq2) - sx8(t9));
			end
			default: ;
		endcase

		o_word.out_p2  = np2 ^ PIX_BIAS;
		o_word.out_p1  = np1 ^ PIX_BIAS;
		o_word.out_p0  = np0 ^ PIX_BIAS;
		o_word.out_q0  = nq0 ^ PIX_BIAS;
		o_word.out_q1  = nq1 ^ PIX_BIAS;
		o_word.out_q2  = nq2 ^ PIX_BIAS;
		o_word.applied = cls_s1.op != OP_PASS;
	end

	assign empty  = ocnt_q == 2'd0;
	assign result = omem_q[ord_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocnt_q    <= '0;
		end else begin
			if (o_push) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (o_pop) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			ocnt_q <= ocnt_q + {1'b0, o_push} - {1'b0, o_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (o_push) begin
			omem_q[owr_ptr_q] <= o_word;
		end
	end

endmodule

// ===== rtl/vp8_loop_filter_edge_core.sv =====
// vp8 loop filter for one edge segment: push a word of eight pixels p3..q3 with its
// edge flags, pop a word with the filtered p2..q2 and an applied flag. one word is
// taken and one delivered every clock cycle when both sides keep moving; a word is
// classified combinationally as it is written into the front queue, then passes
// through the filter value register into the output queue, which the result port
// reads. classifying is combinational and the filter datapath is pipelined, so each
// takes a new word while the last moves on. full rises only when the two word front
// queue and the two word output queue are both backed up. configuration registers
// are written through cfg_we/cfg_idx/cfg_wdata and must only change while the block
// holds no words.
module vp8_loop_filter_edge_core
	import vp8lf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input queue side
	input  logic                  push,
	output logic                  full,
	input  in_word_t              item,
	// result queue side
	output logic                  empty,
	input  logic                  pop,
	output out_word_t             result,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// front to queue
	logic      f_push;
	cls_word_t f_data;
	// queue to back
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	cls_word_t q_data;

	// the input side is full when the front queue is
	assign full = q_full;

	// level, limits and filter choice worked out as the word is accepted
	vp8lf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_data    (f_data)
	);

	// short queue that lets the back end stall without losing the front
	vp8lf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	// pixel arithmetic and the output queue
	vp8lf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/vp8lf_checker.sv =====
module vp8lf_checker
	import vp8lf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_word_t result
);

	// a waiting result stays until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result changed while waiting");

	// the output queue is empty and the input side is not full while reset is held
	a_reset_state: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> empty && !full)
		else $error("queues not empty during reset");

	// the input side backs up only behind a waiting result
	a_full_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full with no result waiting");

endmodule

bind vp8_loop_filter_edge_core vp8lf_checker u_checker (.*);

// ===== tb/sv/vp8_loop_filter_edge_check.sv =====
`timescale 1ns / 100ps

module vp8_loop_filter_edge_check
	import vp8lf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  in_word_t              item,
	input  logic                  empty,
	input  logic                  pop,
	input  out_word_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	// shadow copy of the filter registers
	logic              cf_simple;
	logic [5:0]        cf_level;
	logic [2:0]        cf_sharp;
	logic              cf_delta_on;
	logic signed [6:0] cf_ref_delta;
	logic signed [6:0] cf_mode_delta;

	out_word_t filtered_q[$];

	function automatic int clip8(input int v);
		return v < -128 ? -128 : (v > 127 ? 127 : v);
	endfunction

	function automatic int absv(input int v);
		return v < 0 ? -v : v;
	endfunction

	// p0/q0 adjustment shared by all filters but the wide one, q_step is the q side amount
	task automatic adjust_center(input bit use_outer, input int p1, input int q1,
			inout int p0, inout int q0, output int q_step);
		int a;
		int b;
		a = clip8(3 * (q0 - p0) + (use_outer ? clip8(p1 - q1) : 0));
		b = clip8(a + 3) >>> 3;
		a = clip8(a + 4) >>> 3;
		q0 = clip8(q0 - a);
		p0 = clip8(p0 + b);
		q_step = a;
	endtask

	task automatic filter_segment(input in_word_t seg, output out_word_t r);
		int  p3, p2, p1, p0, q0, q1, q2, q3;
		int  lvl, nb, edge_lim, hev_thr, a, wv;
		bit  edge_ok, hev, fired;
		p3 = int'(seg.pix_p3) - 128;
		p2 = int'(seg.pix_p2) - 128;
		p1 = int'(seg.pix_p1) - 128;
		p0 = int'(seg.pix_p0) - 128;
		q0 = int'(seg.pix_q0) - 128;
		q1 = int'(seg.pix_q1) - 128;
		q2 = int'(seg.pix_q2) - 128;
		q3 = int'(seg.pix_q3) - 128;
		fired = 1'b0;

		lvl = int'(cf_level);
		if (cf_delta_on) begin
			lvl += int'(cf_ref_delta);
			if (seg.is_special_mode)
				lvl += int'(cf_mode_delta);
			lvl = lvl < 0 ? 0 : (lvl > 63 ? 63 : lvl);
		end

		nb = lvl;
		if (cf_sharp != 3'd0) begin
			nb = nb >> ((cf_sharp > 3'd4) ? 2 : 1);
			if (nb > 9 - int'(cf_sharp))
				nb = 9 - int'(cf_sharp);
		end
		if (nb == 0)
			nb = 1;
		edge_lim = seg.is_subblock ? (lvl * 2 + nb) : ((lvl + 2) * 2 + nb);
		hev_thr = lvl >= 40 ? 2 : (lvl >= 15 ? 1 : 0);

		if (lvl != 0) begin
			edge_ok = absv(p0 - q0) * 2 + absv(p1 - q1) / 2 <= edge_lim;
			if (cf_simple) begin
				if (edge_ok) begin
					fired = 1'b1;
					adjust_center(1'b1, p1, q1, p0, q0, a);
				end
			end else if (edge_ok && absv(p3 - p2) <= nb && absv(p2 - p1) <= nb &&
					absv(p1 - p0) <= nb && absv(q3 - q2) <= nb &&
					absv(q2 - q1) <= nb && absv(q1 - q0) <= nb) begin
				hev = absv(p1 - p0) > hev_thr || absv(q1 - q0) > hev_thr;
				fired = 1'b1;
				if (seg.is_subblock) begin
					adjust_center(hev, p1, q1, p0, q0, a);
					if (!hev) begin
						a = (a + 1) >>> 1;
						q1 = clip8(q1 - a);
						p1 = clip8(p1 + a);
					end
				end else if (hev) begin
					adjust_center(1'b1, p1, q1, p0, q0, a);
				end else begin
					// wide macroblock filter, 27/18/9 taps
					wv = clip8(clip8(p1 - q1) + 3 * (q0 - p0));
					a = clip8((27 * wv + 63) >>> 7);
					q0 = clip8(q0 - a);
					p0 = clip8(p0 + a);
					a = clip8((18 * wv + 63) >>> 7);
					q1 = clip8(q1 - a);
					p1 = clip8(p1 + a);
					a = clip8((9 * wv + 63) >>> 7);
					q2 = clip8(q2 - a);
					p2 = clip8(p2 + a);
				end
			end
		end

		r.out_p2  = 8'(clip8(p2) + 128);
		r.out_p1  = 8'(clip8(p1) + 128);
		r.out_p0  = 8'(clip8(p0) + 128);
		r.out_q0  = 8'(clip8(q0) + 128);
		r.out_q1  = 8'(clip8(q1) + 128);
		r.out_q2  = 8'(clip8(q2) + 128);
		r.applied = fired;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			cf_simple     = 1'b0;
			cf_level      = '0;
			cf_sharp      = '0;
			cf_delta_on   = 1'b0;
			cf_ref_delta  = '0;
			cf_mode_delta = '0;
			filtered_q.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			if (pop && !empty) begin
				if (filtered_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: word popped with nothing expected: %h", $realtime,
							result);
				end else begin
					want = filtered_q.pop_front();
					if (result.out_p2 !== want.out_p2 || result.out_p1 !== want.out_p1 ||
							result.out_p0 !== want.out_p0 || result.out_q0 !== want.out_q0 ||
							result.out_q1 !== want.out_q1 || result.out_q2 !== want.out_q2 ||
							result.applied !== want.applied) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("%0t: mismatch exp p2..q2 %h %h %h %h %h %h applied %b",
								$realtime,
								want.out_p2, want.out_p1, want.out_p0,
								want.out_q0, want.out_q1, want.out_q2, want.applied);
							$display(", got %h %h %h %h %h %h applied %b",
								result.out_p2, result.out_p1, result.out_p0,
								result.out_q0, result.out_q1, result.out_q2,
								result.applied);
						end
					end
				end
			end
			if (push && !full) begin
				filter_segment(item, want);
				filtered_q.push_back(want);
			end
			if (cfg_we) begin
				// only the low bits of each register are kept
				case (cfg_idx)
					CFG_FILTER_TYPE:   cf_simple     = cfg_wdata[0];
					CFG_BASE_LEVEL:    cf_level      = cfg_wdata[5:0];
					CFG_SHARPNESS:     cf_sharp      = cfg_wdata[2:0];
					CFG_DELTA_ENABLED: cf_delta_on   = cfg_wdata[0];
					CFG_REF_DELTA:     cf_ref_delta  = cfg_wdata[6:0];
					CFG_MODE_DELTA:    cf_mode_delta = cfg_wdata[6:0];
					default: ;
				endcase
			end
			pending = filtered_q.size();
		end
	end

endmodule

// ===== tb/sv/vp8_loop_filter_edge_core_test.sv =====
`timescale 1ns / 100ps

module vp8_loop_filter_edge_core_test;
	import vp8lf_pkg::*;

	// filter type register values
	localparam logic FT_NORMAL = 1'b0;
	localparam logic FT_SIMPLE = 1'b1;

	// cycles with no word moving on either side before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 120;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_word_t              item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_word_t             result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int pop_hold    = 0;
	int idle_cycles = 0;
	bit no_gaps     = 1'b0;

	vp8_loop_filter_edge_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	vp8_loop_filter_edge_check u_filter_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_pix(input int v);
		return v < 0 ? 0 : (v > 255 ? 255 : v);
	endfunction

	function automatic in_word_t mk_seg(input bit special, input bit sub,
			input int p3, input int p2, input int p1, input int p0,
			input int q0, input int q1, input int q2, input int q3);
		in_word_t s;
		s.is_special_mode = special;
		s.is_subblock     = sub;
		s.pix_p3 = 8'(p3);
		s.pix_p2 = 8'(p2);
		s.pix_p1 = 8'(p1);
		s.pix_p0 = 8'(p0);
		s.pix_q0 = 8'(q0);
		s.pix_q1 = 8'(q1);
		s.pix_q2 = 8'(q2);
		s.pix_q3 = 8'(q3);
		return s;
	endfunction

	// mostly smooth segments with a step at the edge, so the limit check
	// passes often enough to reach the filters; the rest is noise, hard
	// extremes and smooth segments with one pixel knocked out of line
	function automatic in_word_t rand_seg();
		int px [8];
		int kind, step, jump;
		kind = $urandom_range(0, 9);
		step = $urandom_range(0, $urandom_range(1, 12));
		jump = $urandom_range(0, $urandom_range(0, 48));
		// pin the edge near black or white now and then, to push saturation
		if (kind == 6)
			px[3] = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(240, 255);
		else
			px[3] = $urandom_range(0, 255);
		px[4] = clamp_pix(px[3] + ($urandom_range(0, 1) ? jump : -jump));
		for (int i = 2; i >= 0; i--)
			px[i] = clamp_pix(px[i + 1] + int'($urandom_range(0, 2 * step)) - step);
		for (int i = 5; i < 8; i++)
			px[i] = clamp_pix(px[i - 1] + int'($urandom_range(0, 2 * step)) - step);
		if (kind == 7) begin
			for (int i = 0; i < 8; i++)
				px[i] = $urandom_range(0, 255);
		end else if (kind == 8) begin
			for (int i = 0; i < 8; i++)
				px[i] = $urandom_range(0, 1) ? 255 : 0;
		end else if (kind == 9) begin
			px[$urandom_range(0, 7)] = $urandom_range(0, 255);
		end
		return mk_seg($urandom_range(0, 1), $urandom_range(0, 1),
			px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7]);
	endfunction

	// offer a word and hold it until the block takes it; returns on the
	// falling edge after acceptance with push still high
	task automatic send_word(input in_word_t w);
		push <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_paced(input in_word_t w);
		send_word(w);
		if (!no_gaps)
			pause_sender(gap_len());
	endtask

	// stop sending and let every expected word come out
	task automatic wait_for_results();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// write all registers back to back, with junk above the width of each
	// narrower register, and hit the two unused indexes with junk as well
	task automatic program_filter(input logic ftype, input logic [5:0] level,
			input logic [2:0] sharp, input logic delta_on,
			input logic signed [6:0] rdelta, input logic signed [6:0] mdelta);
		logic [CFG_DATA_W-1:0] v;
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			case (cfg_idx_t'(i))
				CFG_FILTER_TYPE:   v = {6'($urandom), ftype};
				CFG_BASE_LEVEL:    v = {1'($urandom), level};
				CFG_SHARPNESS:     v = {4'($urandom), sharp};
				CFG_DELTA_ENABLED: v = {6'($urandom), delta_on};
				CFG_REF_DELTA:     v = rdelta;
				CFG_MODE_DELTA:    v = mdelta;
				default:           v = 7'($urandom);
			endcase
			cfg_we    <= 1'b1;
			cfg_idx   <= 3'(i);
			cfg_wdata <= v;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// result side: pop with random stalls, none while no_gaps is set
	always @(negedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if (!no_gaps)
				pop_hold = gap_len();
		end
	end

	// watchdog on cycles where no word moves on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers at reset value: level zero, every pixel passes
		send_paced(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_paced(mk_seg(1, 1, 255, 255, 255, 255, 255, 255, 255, 255));
		send_paced(mk_seg(1, 0, 85, 170, 85, 170, 85, 170, 85, 170));
		wait_for_results();

		// normal filter at full level, no sharpness
		program_filter(FT_NORMAL, 6'd63, 3'd0, 1'b0, 7'sd0, 7'sd0);
		// low variance macroblock edge: wide filter
		send_paced(mk_seg(0, 0, 100, 100, 101, 102, 110, 111, 111, 111));
		// same edge as a subblock edge: inner filter on p1..q1
		send_paced(mk_seg(0, 1, 100, 100, 101, 102, 110, 111, 111, 111));
		// high edge variance, macroblock and subblock
		send_paced(mk_seg(0, 0, 100, 100, 100, 110, 120, 120, 120, 120));
		send_paced(mk_seg(1, 1, 100, 100, 100, 110, 120, 120, 120, 120));
		// neighbor limit fails: p3 to p2 jump
		send_paced(mk_seg(0, 0, 0, 200, 200, 200, 200, 200, 200, 200));
		// edge limit fails: black against white
		send_paced(mk_seg(0, 0, 0, 0, 0, 0, 255, 255, 255, 255));
		// flat extremes pass the check and come out unchanged
		send_paced(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_paced(mk_seg(0, 1, 255, 255, 255, 255, 255, 255, 255, 255));
		// dark side at the bottom of the range, strong step
		send_paced(mk_seg(0, 0, 0, 0, 0, 0, 70, 70, 70, 70));
		wait_for_results();

		// simple filter: only p0/q0 may change
		program_filter(FT_SIMPLE, 6'd63, 3'd0, 1'b0, 7'sd0, 7'sd0);
		send_paced(mk_seg(0, 0, 20, 60, 90, 100, 140, 150, 200, 250));
		send_paced(mk_seg(0, 1, 0, 0, 0, 0, 255, 255, 255, 255));
		send_paced(mk_seg(1, 0, 255, 255, 255, 255, 255, 255, 255, 255));
		wait_for_results();

		// deltas: plain blocks land on level zero, special mode on the top
		program_filter(FT_NORMAL, 6'd20, 3'd7, 1'b1, -7'sd20, 7'sd63);
		send_paced(mk_seg(0, 0, 100, 101, 102, 103, 104, 105, 106, 107));
		send_paced(mk_seg(1, 0, 100, 101, 102, 103, 104, 105, 106, 107));
		wait_for_results();
		// negative deltas clamp the level at zero
		program_filter(FT_NORMAL, 6'd63, 3'd5, 1'b1, -7'sd63, -7'sd63);
		send_paced(mk_seg(1, 1, 100, 101, 102, 103, 104, 105, 106, 107));
		wait_for_results();

		// random phases, the first few at fixed corner settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_filter(FT_NORMAL, 6'd63, 3'd0, 1'b0, 7'sd0, 7'sd0);
				1: program_filter(FT_SIMPLE, 6'd63, 3'd7, 1'b0, 7'sd0, 7'sd0);
				2: program_filter(FT_NORMAL, 6'd1, 3'd7, 1'b0, 7'sd0, 7'sd0);
				3: program_filter(FT_NORMAL, 6'd40, 3'd4, 1'b1, -7'sd63, 7'sd63);
				4: program_filter(FT_SIMPLE, 6'd15, 3'd5, 1'b1, 7'sd63, -7'sd63);
				default: program_filter($urandom_range(0, 1) ? FT_SIMPLE : FT_NORMAL,
					6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)),
					7'(int'($urandom_range(0, 126)) - 63),
					7'(int'($urandom_range(0, 126)) - 63));
			endcase
			// every fourth phase runs flat out on both sides
			no_gaps = (ph % 4 == 2);
			repeat (PHASE_WORDS)
				send_paced(rand_seg());
			wait_for_results();
		end

		// let any stray word show up before the verdict
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/vp8lf_pkg.sv
rtl/vp8lf_front.sv
rtl/vp8lf_queue.sv
rtl/vp8lf_back.sv
rtl/vp8_loop_filter_edge_core.sv
rtl/vp8lf_checker.sv
tb/sv/vp8_loop_filter_edge_check.sv
tb/sv/vp8_loop_filter_edge_core_test.sv
